@@ rtl/sgpl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgpl_pkg;

   localparam int SAMPLE_BITS_DEF    = 16;
   localparam int COEF_FRAC_BITS_DEF = 16;

   localparam int LVL_BITS   = 15;
   localparam int COEF_BITS  = 17;
   localparam int GAIN_BITS  = 17;
   localparam int CEIL_SHIFT = 16;
   localparam int CEIL_BITS  = LVL_BITS + CEIL_SHIFT;
   localparam int OUT_SHIFT  = 16;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 17'h10000;

   localparam logic [LVL_BITS-1:0]  THRESHOLD_RST = 15'd32767;
   localparam logic [LVL_BITS-1:0]  CEILING_RST   = 15'd32767;
   localparam logic [COEF_BITS-1:0] ATTACK_RST    = 17'd65536;
   localparam logic [COEF_BITS-1:0] RELEASE_RST   = 17'd66;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 17;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CEILING   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ATTACK    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELEASE   = 2'd3;

   typedef struct packed {
      logic load;
      logic set_unity;
      logic pass;
      logic prod;
      logic tgt_unity;
      logic tgt_gain;
      logic div_start;
      logic tgt_quot;
      logic smul;
      logic sadd;
      logic omul;
      logic oset;
   } dp_cmd_type;

   typedef struct packed {
      logic cmd_reset;
      logic cfg_err;
      logic above;
      logic over;
      logic div_done;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/sgpl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpl_div #(
   parameter int DIVISOR_BITS = sgpl_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sgpl_pkg::CEIL_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]        divisor,
   output logic      [sgpl_pkg::GAIN_BITS-1:0] quotient,
   output logic                                done
);

   localparam int QB   = sgpl_pkg::GAIN_BITS;
   localparam int DB   = sgpl_pkg::CEIL_BITS;
   localparam int RW   = (DIVISOR_BITS + 1 > DB - QB + 1) ? DIVISOR_BITS + 1 : DB - QB + 1;
   localparam int CNTW = $clog2(QB + 1);

   logic [RW-1:0]   rem_ff, rem_in;
   logic [QB-1:0]   low_ff, low_in;
   logic [QB-1:0]   quot_ff, quot_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [RW-1:0]   trial;
   logic [RW-1:0]   div_ext;
   logic            ge;

   // quotient fits in QB bits, so the top dividend bits seed the remainder
   assign trial   = {rem_ff[RW-2:0], low_ff[QB-1]};
   assign div_ext = RW'(divisor);
   assign ge      = trial >= div_ext;

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = RW'(dividend >> QB);
         low_in  = dividend[QB-1:0];
         cnt_in  = CNTW'(QB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (trial - div_ext) : trial;
         low_in  = {low_ff[QB-2:0], 1'b0};
         quot_in = {quot_ff[QB-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a running division");

endmodule

`default_nettype wire

@@ rtl/sgpl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpl_dp #(
   parameter int SAMPLE_BITS    = sgpl_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = sgpl_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sgpl_pkg::dp_cmd_type               cmd,
   output sgpl_pkg::dp_status_type                 status,
   input  wire logic                               csr_wr_en,
   input  wire logic [sgpl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [sgpl_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                               req_command,
   input  wire logic [SAMPLE_BITS-1:0]             req_sample,
   output logic      [SAMPLE_BITS-1:0]             res_sample,
   output logic      [sgpl_pkg::GAIN_BITS-1:0]     res_gain,
   output logic                                    res_err
);

   localparam int GB   = sgpl_pkg::GAIN_BITS;
   localparam int LB   = sgpl_pkg::LVL_BITS;
   localparam int CB   = sgpl_pkg::COEF_BITS;
   localparam int CMPW = (SAMPLE_BITS > LB) ? SAMPLE_BITS : LB;
   localparam int PW   = SAMPLE_BITS + GB;
   localparam int PCW  = (PW > sgpl_pkg::CEIL_BITS) ? PW : sgpl_pkg::CEIL_BITS;
   localparam int CWD  = (COEF_FRAC_BITS + 1 > CB) ? COEF_FRAC_BITS + 1 : CB;
   localparam int SW   = CWD + GB + 2;
   localparam int OW   = SAMPLE_BITS + GB + 1;

   logic [LB-1:0]                 thr_ff, ceil_ff;
   logic [CB-1:0]                 atk_ff, rel_ff;
   logic [GB-1:0]                 gain_ff, gain_in;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0]        mag_ff, mag_in;
   logic                          cmd_ff, err_ff;
   logic [PW-1:0]                 prod_ff;
   logic [GB-1:0]                 target_ff;
   logic signed [SW-1:0]          step_ff, step_in;
   logic signed [OW-1:0]          oprod_ff, oprod_in;
   logic [SAMPLE_BITS-1:0]        res_sample_ff;

   logic                          cfg_err;
   logic                          above;
   logic                          over;
   logic [sgpl_pkg::CEIL_BITS-1:0] ceil_sh;
   logic [CB-1:0]                 coef_raw;
   logic [CWD-1:0]                coef_ext, coef_one, coef_sat;
   logic signed [GB:0]            diff;
   logic signed [SW-1:0]          step_sh, gain_sw, ng;
   logic signed [OW-1:0]          y_full;
   logic [GB-1:0]                 quot;
   logic                          div_done;

   assign mag_in  = req_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~req_sample + 1'b1) : req_sample;
   assign cfg_err = (ceil_ff < thr_ff) || (thr_ff == '0);
   assign above   = CMPW'(mag_ff) > CMPW'(thr_ff);
   assign ceil_sh = {ceil_ff, {sgpl_pkg::CEIL_SHIFT{1'b0}}};
   assign over    = PCW'(prod_ff) > PCW'(ceil_sh);

   // coefficients above one saturate to one
   assign coef_raw = above ? atk_ff : rel_ff;
   assign coef_ext = CWD'(coef_raw);
   assign coef_one = CWD'(1) << COEF_FRAC_BITS;
   assign coef_sat = (coef_ext > coef_one) ? coef_one : coef_ext;
   assign diff     = $signed({1'b0, target_ff}) - $signed({1'b0, gain_ff});
   assign step_in  = $signed({1'b0, coef_sat}) * diff;

   assign step_sh = step_ff >>> COEF_FRAC_BITS;
   assign gain_sw = signed'(SW'(gain_ff));
   assign ng      = gain_sw + step_sh;

   always_comb begin
      gain_in = gain_ff;
      if (cmd.set_unity) begin
         gain_in = sgpl_pkg::GAIN_ONE;
      end else if (cmd.sadd) begin
         priority if (ng[SW-1]) begin
            gain_in = '0;
         end else if (ng > signed'(SW'(sgpl_pkg::GAIN_ONE))) begin
            gain_in = sgpl_pkg::GAIN_ONE;
         end else begin
            gain_in = ng[GB-1:0];
         end
      end
   end

   assign oprod_in = x_ff * $signed({1'b0, gain_ff});
   assign y_full   = oprod_ff >>> sgpl_pkg::OUT_SHIFT;

   sgpl_div #(
      .DIVISOR_BITS(SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (ceil_sh),
      .divisor  (mag_ff),
      .quotient (quot),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= sgpl_pkg::THRESHOLD_RST;
         ceil_ff <= sgpl_pkg::CEILING_RST;
         atk_ff  <= sgpl_pkg::ATTACK_RST;
         rel_ff  <= sgpl_pkg::RELEASE_RST;
         gain_ff <= sgpl_pkg::GAIN_ONE;
      end else begin
         gain_ff <= gain_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               sgpl_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata[LB-1:0];
               sgpl_pkg::CSR_CEILING:   ceil_ff <= csr_wdata[LB-1:0];
               sgpl_pkg::CSR_ATTACK:    atk_ff  <= csr_wdata[CB-1:0];
               sgpl_pkg::CSR_RELEASE:   rel_ff  <= csr_wdata[CB-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= signed'(req_sample);
         mag_ff <= mag_in;
         cmd_ff <= req_command;
         err_ff <= cfg_err;
      end
      if (cmd.prod) begin
         prod_ff <= mag_ff * gain_ff;
      end
      priority if (cmd.tgt_unity) begin
         target_ff <= sgpl_pkg::GAIN_ONE;
      end else if (cmd.tgt_gain) begin
         target_ff <= gain_ff;
      end else if (cmd.tgt_quot) begin
         target_ff <= quot;
      end
      if (cmd.smul) begin
         step_ff <= step_in;
      end
      if (cmd.omul) begin
         oprod_ff <= oprod_in;
      end
      priority if (cmd.set_unity) begin
         res_sample_ff <= '0;
      end else if (cmd.pass) begin
         res_sample_ff <= x_ff;
      end else if (cmd.oset) begin
         res_sample_ff <= y_full[SAMPLE_BITS-1:0];
      end
   end

   assign status.cmd_reset = cmd_ff;
   assign status.cfg_err   = err_ff;
   assign status.above     = above;
   assign status.over      = over;
   assign status.div_done  = div_done;

   assign res_sample = res_sample_ff;
   assign res_gain   = gain_ff;
   assign res_err    = err_ff;

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      gain_ff <= sgpl_pkg::GAIN_ONE)
      else $error("gain above unity");

   a_quot_below_gain: assert property (@(posedge clock) disable iff (reset)
      cmd.tgt_quot |-> (quot < gain_ff))
      else $error("limiting target not below current gain");

endmodule

`default_nettype wire

@@ rtl/sgpl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgpl_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    out_free,
   input  wire sgpl_pkg::dp_status_type status,
   output sgpl_pkg::dp_cmd_type         cmd,
   output logic                         in_ready,
   output logic                         out_load
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EVAL   = 4'd1;
   localparam logic [3:0] ST_CMP    = 4'd2;
   localparam logic [3:0] ST_DIV    = 4'd3;
   localparam logic [3:0] ST_SMUL   = 4'd4;
   localparam logic [3:0] ST_SADD   = 4'd5;
   localparam logic [3:0] ST_OMUL   = 4'd6;
   localparam logic [3:0] ST_OSET   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      out_load = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (status.cmd_reset) begin
               cmd.set_unity = 1'b1;
               state_in      = ST_FINISH;
            end else if (status.cfg_err) begin
               cmd.pass = 1'b1;
               state_in = ST_FINISH;
            end else if (status.above) begin
               cmd.prod = 1'b1;
               state_in = ST_CMP;
            end else begin
               cmd.tgt_unity = 1'b1;
               state_in      = ST_SMUL;
            end
         end
         ST_CMP: begin
            if (status.over) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.tgt_gain = 1'b1;
               state_in     = ST_SMUL;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.tgt_quot = 1'b1;
               state_in     = ST_SMUL;
            end
         end
         ST_SMUL: begin
            cmd.smul = 1'b1;
            state_in = ST_SADD;
         end
         ST_SADD: begin
            cmd.sadd = 1'b1;
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            cmd.omul = 1'b1;
            state_in = ST_OSET;
         end
         ST_OSET: begin
            cmd.oset = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/smoothed_gain_peak_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A gain reset or a bad configuration goes from evaluation straight to the finish state; at
// or below threshold a request passes the step multiply, step add, output multiply and output
// set states, and above it a ceiling compare comes first; when limiting, the 17-step restoring
// divider for ceiling/magnitude runs before the step states. One request is in work
// at a time; the next is accepted once the result moves into the output register.
// Synchronous reset: gain returns to unity, registers to their defaults, no result pending.
module smoothed_gain_peak_limiter #(
   parameter int SAMPLE_BITS    = sgpl_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = sgpl_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   // [SAMPLE_BITS-1:0] sample_in, rest zero
   input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // [0] command
   input  wire logic                                     req_tuser,
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // [SAMPLE_BITS-1:0] sample_out, [SAMPLE_BITS+16:SAMPLE_BITS] gain_now, rest zero
   output logic [((SAMPLE_BITS + sgpl_pkg::GAIN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [0] config_error
   output logic                                          rsp_tuser,
   input  wire logic                                     csr_wr_en,
   input  wire logic [sgpl_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  wire logic [sgpl_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int GB    = sgpl_pkg::GAIN_BITS;
   localparam int RSP_W = ((SAMPLE_BITS + GB + 7) / 8) * 8;

   sgpl_pkg::dp_cmd_type    cmd;
   sgpl_pkg::dp_status_type status;

   logic [SAMPLE_BITS-1:0] res_sample;
   logic [GB-1:0]          res_gain;
   logic                   res_err;
   logic                   out_load;
   logic                   out_free;

   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff;
   logic [GB-1:0]          out_gain_ff;
   logic                   out_err_ff;

   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   sgpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd),
      .in_ready  (req_tready),
      .out_load  (out_load)
   );

   sgpl_dp #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_command (req_tuser),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .res_sample  (res_sample),
      .res_gain    (res_gain),
      .res_err     (res_err)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_sample_ff <= res_sample;
         out_gain_ff   <= res_gain;
         out_err_ff    <= res_err;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_gain_ff, out_sample_ff});
   assign rsp_tuser  = out_err_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded over a pending response");

   a_idle_when_accepting: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !out_load)
      else $error("request accepted while a result is being loaded");

endmodule

`default_nettype wire
